FILE: rtl/core/vector_distance_engine_defines.svh
// Assertion macros for the vector distance engine.
// Used by the front, job queue and back modules; expects clk and rst_n in scope.
`ifndef VECTOR_DISTANCE_ENGINE_DEFINES_SVH
`define VECTOR_DISTANCE_ENGINE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled during reset.
`define VDE_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define VDE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define VDE_ASSERT(lbl, ante, cons, msg)
`define VDE_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

FILE: rtl/core/vde_pkg.sv
// Shared types, widths and helpers for the vector distance engine.
// No dependencies; used by every other file of the block but the assertion-macro header.
`default_nettype none

package vde_pkg;

  localparam int MAX_DIM   = 4096;
  localparam int ELEM_BITS = 16;

  localparam int ELEM_W   = 16;
  localparam int DIFF_D_W = ELEM_W + 1;
  localparam int PROD_W   = 2 * ELEM_W;
  localparam int SQ_W     = 2 * DIFF_D_W;
  localparam int DOT_W    = 44;
  localparam int DIFF_W   = 45;
  localparam int OUT_W    = 44;
  localparam int CNT_W    = $clog2(MAX_DIM + 1);

  // Digit-by-digit root of diff * 2^30
  localparam int Q30_SHIFT  = 30;
  localparam int ROOT_STEPS = 38;
  localparam int ROOT_W     = ROOT_STEPS;
  localparam int REM_W      = ROOT_W + 3;
  localparam int OPND_W     = 2 * ROOT_STEPS;
  localparam int STEP_W     = $clog2(ROOT_STEPS);
  localparam logic [Q30_SHIFT:0] Q30_ONE = (Q30_SHIFT + 1)'(1) << Q30_SHIFT;

  localparam int JOBQ_DEPTH = 2;
  localparam int JOBQ_AW    = $clog2(JOBQ_DEPTH);
  localparam int JOBQ_CW    = $clog2(JOBQ_DEPTH + 1);

  // Configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_IDX_W  = CFG_ADDR_W - 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_METRIC = CFG_IDX_W'(0);

  typedef enum logic [1:0] {
    METRIC_COSINE = 2'd0,
    METRIC_EUCLID = 2'd1,
    METRIC_DOT    = 2'd2
  } metric_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_ROOT,
    BK_EMIT
  } bk_state_t;

  typedef struct packed {
    logic signed [DOT_W-1:0] dot;
    logic [DIFF_W-1:0]       diff;
    logic                    too_long;
  } job_t;

  // Keep the low ELEM_BITS bits, sign-extend and scale back to Q1.15.
  function automatic logic signed [ELEM_W-1:0] load_elem(input logic [ELEM_W-1:0] raw);
    logic signed [ELEM_W-1:0] v;
    v = ELEM_W'($signed(raw[ELEM_BITS-1:0]));
    return v <<< (ELEM_W - ELEM_BITS);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/vde_if.sv
// Valid/ready channel interfaces for element pairs and distance results.
// Widths come from vde_pkg.
`default_nettype none

interface vde_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [vde_pkg::ELEM_W-1:0]    elem_a;
  logic signed [vde_pkg::ELEM_W-1:0]    elem_b;
  logic                                 last;

  modport source (output valid, elem_a, elem_b, last, input ready);
  modport sink   (input valid, elem_a, elem_b, last, output ready);
endinterface

interface vde_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [vde_pkg::OUT_W-1:0]     distance_value;
  logic                                 too_long;

  modport source (output valid, distance_value, too_long, input ready);
  modport sink   (input valid, distance_value, too_long, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/vde_front.sv
// Front end: takes element pairs, multiplies, and keeps the running sums.
// Pushes one job per vector into the job queue. Depends on vde_pkg, vde_if.
`default_nettype none
`include "vector_distance_engine_defines.svh"

module vde_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  vde_in_if.sink             in_ch,
  output vde_pkg::job_t      job_data,
  output logic               job_push,
  input  wire logic          job_full
);

  logic signed [vde_pkg::ELEM_W-1:0]   a_s, b_s;
  logic signed [vde_pkg::DIFF_D_W-1:0] d_s;
  logic signed [vde_pkg::PROD_W-1:0]   prod_s;
  logic signed [vde_pkg::SQ_W-1:0]     sq_s;

  logic                              accept;
  logic                              full_hit;
  logic [vde_pkg::CNT_W-1:0]         cnt_r, cnt_nxt;
  logic                              ovf_r, ovf_nxt;

  logic                              s1_v_r, s1_v_nxt;
  logic signed [vde_pkg::PROD_W-1:0] s1_prod_r;
  logic [vde_pkg::SQ_W-2:0]          s1_sq_r;
  logic                              s1_last_r, s1_skip_r, s1_tl_r;
  logic                              s1_adv;

  logic signed [vde_pkg::DOT_W-1:0]  dot_r, dot_nxt, dot_new;
  logic [vde_pkg::DIFF_W-1:0]        diff_r, diff_nxt, diff_new;
  logic signed [vde_pkg::DOT_W:0]    dot_sum;
  logic [vde_pkg::DIFF_W:0]          diff_sum;

  // Stage 1: multiply
  always_comb begin
    a_s    = vde_pkg::load_elem(in_ch.elem_a);
    b_s    = vde_pkg::load_elem(in_ch.elem_b);
    d_s    = vde_pkg::DIFF_D_W'(a_s) - vde_pkg::DIFF_D_W'(b_s);
    prod_s = vde_pkg::PROD_W'(a_s) * vde_pkg::PROD_W'(b_s);
    sq_s   = vde_pkg::SQ_W'(d_s) * vde_pkg::SQ_W'(d_s);
  end

  // Hold the last beat of a vector while the queue is full.
  assign s1_adv      = s1_v_r && !(s1_last_r && job_full);
  assign in_ch.ready = !s1_v_r || s1_adv;
  assign accept      = in_ch.valid && in_ch.ready;
  assign full_hit    = (cnt_r >= vde_pkg::CNT_W'(vde_pkg::MAX_DIM));

  always_comb begin
    cnt_nxt  = cnt_r;
    ovf_nxt  = ovf_r;
    s1_v_nxt = s1_v_r;
    if (accept) begin
      s1_v_nxt = 1'b1;
      if (in_ch.last) begin
        cnt_nxt = '0;
        ovf_nxt = 1'b0;
      end else if (full_hit) begin
        ovf_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r + vde_pkg::CNT_W'(1);
      end
    end else if (s1_adv) begin
      s1_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      ovf_r  <= 1'b0;
      s1_v_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      ovf_r  <= ovf_nxt;
      s1_v_r <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_prod_r <= prod_s;
      s1_sq_r   <= sq_s[vde_pkg::SQ_W-2:0];
      s1_last_r <= in_ch.last;
      s1_skip_r <= full_hit;
      s1_tl_r   <= ovf_r || full_hit;
    end
  end

  // Stage 2: accumulate with saturation
  always_comb begin
    dot_sum  = (vde_pkg::DOT_W + 1)'(dot_r) + (vde_pkg::DOT_W + 1)'(s1_prod_r);
    diff_sum = (vde_pkg::DIFF_W + 1)'(diff_r) + (vde_pkg::DIFF_W + 1)'(s1_sq_r);
    if (dot_sum[vde_pkg::DOT_W] != dot_sum[vde_pkg::DOT_W-1]) begin
      dot_new = dot_sum[vde_pkg::DOT_W] ? {1'b1, {(vde_pkg::DOT_W-1){1'b0}}}
                                        : {1'b0, {(vde_pkg::DOT_W-1){1'b1}}};
    end else begin
      dot_new = dot_sum[vde_pkg::DOT_W-1:0];
    end
    diff_new = diff_sum[vde_pkg::DIFF_W] ? {vde_pkg::DIFF_W{1'b1}}
                                         : diff_sum[vde_pkg::DIFF_W-1:0];
    if (s1_skip_r) begin
      dot_new  = dot_r;
      diff_new = diff_r;
    end

    job_data.dot      = dot_new;
    job_data.diff     = diff_new;
    job_data.too_long = s1_tl_r;
    job_push          = s1_adv && s1_last_r;

    dot_nxt  = dot_r;
    diff_nxt = diff_r;
    if (s1_adv) begin
      dot_nxt  = s1_last_r ? '0 : dot_new;
      diff_nxt = s1_last_r ? '0 : diff_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dot_r  <= '0;
      diff_r <= '0;
    end else begin
      dot_r  <= dot_nxt;
      diff_r <= diff_nxt;
    end
  end

  `VDE_ASSERT(a_cnt_bound, 1'b1, cnt_r <= vde_pkg::CNT_W'(vde_pkg::MAX_DIM), "element count past limit")

endmodule

`default_nettype wire

FILE: rtl/core/vde_job_fifo.sv
// Short queue of finished sums between the front and back ends.
// Depends on vde_pkg for the job type and depth.
`default_nettype none
`include "vector_distance_engine_defines.svh"

module vde_job_fifo (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire vde_pkg::job_t  push_data,
  output logic                full,
  input  wire logic           pop,
  output vde_pkg::job_t       pop_data,
  output logic                empty
);

  vde_pkg::job_t                mem [vde_pkg::JOBQ_DEPTH];
  logic [vde_pkg::JOBQ_AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [vde_pkg::JOBQ_AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [vde_pkg::JOBQ_CW-1:0]  cnt_r, cnt_nxt;

  assign full     = (cnt_r == vde_pkg::JOBQ_CW'(vde_pkg::JOBQ_DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == vde_pkg::JOBQ_AW'(vde_pkg::JOBQ_DEPTH - 1))
                   ? '0 : wr_ptr_r + vde_pkg::JOBQ_AW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == vde_pkg::JOBQ_AW'(vde_pkg::JOBQ_DEPTH - 1))
                   ? '0 : rd_ptr_r + vde_pkg::JOBQ_AW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + vde_pkg::JOBQ_CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - vde_pkg::JOBQ_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  `VDE_ASSERT(a_no_overrun, push, !full, "job pushed into full queue")
  `VDE_ASSERT(a_no_underrun, pop, !empty, "job popped from empty queue")

endmodule

`default_nettype wire

FILE: rtl/core/vde_back.sv
// Back end: applies the metric to a job, runs the iterative square root for the
// euclidean metric, and holds the result in the output register. Depends on vde_pkg, vde_if.
`default_nettype none
`include "vector_distance_engine_defines.svh"

module vde_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire vde_pkg::metric_t metric,
  input  wire vde_pkg::job_t    job,
  input  wire logic             job_empty,
  output logic                  job_pop,
  vde_out_if.source             out_ch
);

  vde_pkg::bk_state_t                st_r, st_nxt;
  logic signed [vde_pkg::OUT_W-1:0]  res_r, res_nxt;
  logic                              tl_r, tl_nxt;
  logic [vde_pkg::OPND_W-1:0]        op_r, op_nxt;
  logic [vde_pkg::ROOT_W-1:0]        root_r, root_nxt;
  logic [vde_pkg::REM_W-1:0]         rem_r, rem_nxt;
  logic [vde_pkg::STEP_W-1:0]        step_r, step_nxt;
  logic                              out_v_r, out_v_nxt;
  logic signed [vde_pkg::OUT_W-1:0]  dist_r, dist_nxt;
  logic                              out_tl_r, out_tl_nxt;

  logic [vde_pkg::REM_W-1:0]         rem_sh, trial;
  logic                              slot_free;

  function automatic logic signed [vde_pkg::OUT_W-1:0] sat_out(
      input logic signed [vde_pkg::OUT_W:0] v);
    logic signed [vde_pkg::OUT_W-1:0] r;
    if (v[vde_pkg::OUT_W] != v[vde_pkg::OUT_W-1]) begin
      r = v[vde_pkg::OUT_W] ? {1'b1, {(vde_pkg::OUT_W-1){1'b0}}}
                            : {1'b0, {(vde_pkg::OUT_W-1){1'b1}}};
    end else begin
      r = v[vde_pkg::OUT_W-1:0];
    end
    return r;
  endfunction

  assign slot_free = !out_v_r || out_ch.ready;

  always_comb begin
    st_nxt     = st_r;
    res_nxt    = res_r;
    tl_nxt     = tl_r;
    op_nxt     = op_r;
    root_nxt   = root_r;
    rem_nxt    = rem_r;
    step_nxt   = step_r;
    out_v_nxt  = out_v_r;
    dist_nxt   = dist_r;
    out_tl_nxt = out_tl_r;
    job_pop    = 1'b0;

    rem_sh = {rem_r[vde_pkg::REM_W-3:0], op_r[vde_pkg::OPND_W-1 -: 2]};
    trial  = vde_pkg::REM_W'({root_r, 2'b01});

    // Drop the result once taken.
    if (out_v_r && out_ch.ready) begin
      out_v_nxt = 1'b0;
    end

    unique case (st_r)
      vde_pkg::BK_IDLE: begin
        if (!job_empty) begin
          job_pop = 1'b1;
          tl_nxt  = job.too_long;
          st_nxt  = vde_pkg::BK_EMIT;
          unique case (metric)
            vde_pkg::METRIC_COSINE:
              res_nxt = sat_out((vde_pkg::OUT_W + 1)'(vde_pkg::Q30_ONE)
                                - (vde_pkg::OUT_W + 1)'(job.dot));
            vde_pkg::METRIC_EUCLID: begin
              op_nxt   = vde_pkg::OPND_W'({job.diff, {vde_pkg::Q30_SHIFT{1'b0}}});
              root_nxt = '0;
              rem_nxt  = '0;
              step_nxt = vde_pkg::STEP_W'(vde_pkg::ROOT_STEPS - 1);
              st_nxt   = vde_pkg::BK_ROOT;
            end
            vde_pkg::METRIC_DOT:
              res_nxt = sat_out((vde_pkg::OUT_W + 1)'(0)
                                - (vde_pkg::OUT_W + 1)'(job.dot));
            default:
              res_nxt = '0;
          endcase
        end
      end
      vde_pkg::BK_ROOT: begin
        // One result bit per cycle.
        if (rem_sh >= trial) begin
          rem_nxt  = rem_sh - trial;
          root_nxt = {root_r[vde_pkg::ROOT_W-2:0], 1'b1};
        end else begin
          rem_nxt  = rem_sh;
          root_nxt = {root_r[vde_pkg::ROOT_W-2:0], 1'b0};
        end
        op_nxt = op_r << 2;
        if (step_r == '0) begin
          res_nxt = vde_pkg::OUT_W'(root_nxt);
          st_nxt  = vde_pkg::BK_EMIT;
        end else begin
          step_nxt = step_r - vde_pkg::STEP_W'(1);
        end
      end
      vde_pkg::BK_EMIT: begin
        if (slot_free) begin
          out_v_nxt  = 1'b1;
          dist_nxt   = res_r;
          out_tl_nxt = tl_r;
          st_nxt     = vde_pkg::BK_IDLE;
        end
      end
      default: st_nxt = vde_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= vde_pkg::BK_IDLE;
      out_v_r <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r    <= res_nxt;
    tl_r     <= tl_nxt;
    op_r     <= op_nxt;
    root_r   <= root_nxt;
    rem_r    <= rem_nxt;
    step_r   <= step_nxt;
    dist_r   <= dist_nxt;
    out_tl_r <= out_tl_nxt;
  end

  assign out_ch.valid          = out_v_r;
  assign out_ch.distance_value = dist_r;
  assign out_ch.too_long       = out_tl_r;

  `VDE_ASSERT_NEXT(a_root_done, (st_r == vde_pkg::BK_ROOT) && (step_r == '0), st_r == vde_pkg::BK_EMIT, "root did not finish on last step")

endmodule

`default_nettype wire

FILE: rtl/core/vector_distance_engine.sv
// The last beat is registered in the front stage, queued as a job, popped by the
// back end (euclidean also runs the 38-step root recurrence) and registered as
// the output. The front takes one element pair per cycle unless a last beat
// waits on a full queue; the back end pops no new job before its result is out.
// A two-entry job queue lets the front keep streaming while a root is in flight.
// Reset (rst_n, synchronous, active low) clears sums, counters, queue and metric.
`default_nettype none

module vector_distance_engine (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  vde_in_if.sink                                  in_ch,
  vde_out_if.source                               out_ch,
  input  wire logic                               cfg_psel,
  input  wire logic                               cfg_penable,
  input  wire logic                               cfg_pwrite,
  input  wire logic [vde_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  wire logic [vde_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [vde_pkg::CFG_DATA_W-1:0]          cfg_prdata,
  output logic                                    cfg_pready
);

  vde_pkg::metric_t                 metric_r, metric_nxt;
  logic [vde_pkg::CFG_IDX_W-1:0]    cfg_idx;
  logic                             cfg_wr;

  vde_pkg::job_t                    push_data, pop_data;
  logic                             job_push, job_full, job_pop, job_empty;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[vde_pkg::CFG_ADDR_W-1:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    metric_nxt = metric_r;
    if (cfg_wr && (cfg_idx == vde_pkg::REG_METRIC)) begin
      metric_nxt = vde_pkg::metric_t'(cfg_pwdata[1:0]);
    end
    cfg_prdata = '0;
    if (cfg_idx == vde_pkg::REG_METRIC) begin
      cfg_prdata = vde_pkg::CFG_DATA_W'(metric_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      metric_r <= vde_pkg::METRIC_COSINE;
    end else begin
      metric_r <= metric_nxt;
    end
  end

  vde_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .job_data (push_data),
    .job_push (job_push),
    .job_full (job_full)
  );

  vde_job_fifo u_jobq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_push),
    .push_data (push_data),
    .full      (job_full),
    .pop       (job_pop),
    .pop_data  (pop_data),
    .empty     (job_empty)
  );

  vde_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .metric    (metric_r),
    .job       (pop_data),
    .job_empty (job_empty),
    .job_pop   (job_pop),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire
